/* sv/dsda_pkg.sv */
// shared types, constants and helper functions for the dual spring damper animator
package dsda_pkg;

	localparam int FRAC_W          = 16;
	localparam int STEP_W          = 16;
	localparam int POS_W           = 32;
	localparam int VEL_W           = 40;
	localparam int LVL_W           = 8 + FRAC_W;
	localparam int EXT_W           = 34;
	localparam int KD_W            = 44;
	localparam int MUL_A_W         = 49;
	localparam int MUL_B_W         = 13;
	localparam int MUL_P_W         = 62;
	localparam int DT_W            = 12;
	localparam int TY_W            = 13;
	localparam int TA_W            = 8;
	localparam int RY_W            = 15;
	localparam int MASK_W          = 8;
	localparam int HGT_W           = 13;
	localparam int NUM_W           = 21;
	localparam int GUARD_W         = 8;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = 13;
	localparam int S_TDATA_W       = 40;
	localparam int M_TDATA_W       = 40;
	localparam int GUARD_LIMIT_DEF = 30;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_Y_EN,
		REG_Y_TENS,
		REG_Y_FRIC,
		REG_A_EN,
		REG_A_TENS,
		REG_A_FRIC,
		REG_SCR_H,
		REG_MASK_MAX
	} cfg_reg_t;

	typedef logic signed [MUL_P_W-1:0] prod_t;

	// request to the quotient unit
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [HGT_W-1:0] den;
	} div_req_t;

	localparam prod_t VEL_MAX = prod_t'((64'sd1 <<< (VEL_W - 1)) - 64'sd1);
	localparam prod_t VEL_MIN = prod_t'(-(64'sd1 <<< (VEL_W - 1)));
	localparam prod_t POS_MAX = prod_t'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
	localparam prod_t POS_MIN = prod_t'(-(64'sd1 <<< (POS_W - 1)));
	localparam prod_t LVL_MAX = prod_t'(64'sd255 <<< FRAC_W);

	localparam logic [LVL_W-1:0] LVL_RST = {8'hFF, {FRAC_W{1'b0}}};
	localparam logic signed [RY_W-1:0] LAST_Y_RST = -15'sd9999;
	localparam logic signed [EXT_W-1:0] ONE_E = EXT_W'(64'sd1 <<< FRAC_W);
	localparam logic signed [VEL_W-1:0] TWO_V = VEL_W'(64'sd2 <<< FRAC_W);

	// product shifted down by the step fraction, rounded toward zero
	function automatic prod_t trunc_step(prod_t x);
		prod_t bias;
		prod_t s;
		bias = x[MUL_P_W-1] ? prod_t'((64'sd1 <<< STEP_W) - 64'sd1) : prod_t'(0);
		s = x + bias;
		return s >>> STEP_W;
	endfunction

	// dt * 7 / 10, truncated; reciprocal multiply exact for 16-bit dividends
	function automatic logic [DT_W-1:0] slow_scale(logic [DT_W-1:0] dt);
		logic [DT_W+2:0] dt7;
		logic [DT_W+18:0] prod;
		dt7 = {3'b000, dt} + {2'b00, dt, 1'b0} + {1'b0, dt, 2'b00};
		prod = (DT_W+19)'(dt7) * (DT_W+19)'(17'd52429);
		return prod[DT_W+18:19];
	endfunction

	// v / 255 for v below 65535
	function automatic logic [MASK_W-1:0] div255(logic [15:0] v);
		logic [16:0] s;
		s = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
		return s[15:8];
	endfunction

endpackage

/* sv/dsda_mul.sv */
// shared signed by unsigned multiplier with registered product
module dsda_mul (
	input  logic                                 clk,
	input  logic signed [dsda_pkg::MUL_A_W-1:0]  a,
	input  logic        [dsda_pkg::MUL_B_W-1:0]  b,
	output dsda_pkg::prod_t                      p
);
	import dsda_pkg::*;

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= prod_t'(a) * prod_t'($signed({1'b0, b}));
	end

	assign p = p_q;

endmodule

/* sv/dsda_div.sv */
// restoring divider, one quotient bit per cycle, 8-bit quotient
module dsda_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dsda_pkg::div_req_t             req,
	output logic                           done,
	output logic [dsda_pkg::MASK_W-1:0]    quo
);
	import dsda_pkg::*;

	logic [NUM_W-1:0]  rem_q;
	logic [MASK_W-1:0] quo_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  dsh;
	logic              ge;

	assign dsh = NUM_W'(req.den) << cnt_q;
	assign ge  = rem_q >= dsh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.num;
				quo_q  <= '0;
				cnt_q  <= 3'd7;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - dsh;
				end
				quo_q <= {quo_q[MASK_W-2:0], ge};
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* sv/dual_spring_damper_animator.sv */
// top level: two spring-damper axes stepped on one shared multiplier
//
// Each input transaction is one animation tick: time step, target offset,
// target opacity, and in tuser the slow-start flag that scales the step by
// 0.7. Both axes are stepped by semi-implicit Euler, one after the other,
// on one registered multiplier under a small sequencer; the drawer mask
// uses a restoring divider. One output transaction per tick.
// A disabled axis is reset and skipped; an enabled axis runs through the
// spring, damping, acceleration, velocity and position steps. With the
// mask on, the mask follows from the opacity, saturates or is divided.
// s_tready is high only while no tick is in work, so one tick is taken
// at a time, at best in the cycle after the previous result is registered;
// the next tick can be taken while the previous result still waits in the
// output register.
// If the receiver stalls, the result holds in m_tdata and the following
// tick stops before its result until the register frees up.
// Config writes land at once; issue them only between ticks.
// Reset: opacity 255, offset 0, velocities 0, registers at defaults.
module dual_spring_damper_animator #(
	parameter int GUARD_LIMIT = dsda_pkg::GUARD_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// time_step[11:0], target_y[24:12], target_alpha[32:25], zero fill
	input  logic [dsda_pkg::S_TDATA_W-1:0]      s_tdata,
	// slow_start[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// render_y[14:0], render_alpha[22:15], mask_alpha[30:23], y_changed[31],
	// alpha_changed[32], mask_changed[33], idle[34], restack_pulse[35], zero fill
	output logic [dsda_pkg::M_TDATA_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [dsda_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [dsda_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import dsda_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AXIS,
		S_KD,
		S_CV,
		S_ACC,
		S_ADT,
		S_VEL,
		S_VDT,
		S_POS,
		S_MASK,
		S_MWAIT,
		S_DIV,
		S_FIN
	} state_t;

	// configuration
	logic               y_en_q;
	logic [9:0]         y_tens_q;
	logic [7:0]         y_fric_q;
	logic               a_en_q;
	logic [9:0]         a_tens_q;
	logic [7:0]         a_fric_q;
	logic [HGT_W-1:0]   scr_h_q;
	logic [MASK_W-1:0]  mask_max_q;

	// tick and axis state
	state_t                   state_q;
	logic                     axis_q;
	logic [DT_W-1:0]          dt_q;
	logic [TY_W-1:0]          ty_q;
	logic [TA_W-1:0]          ta_q;
	logic signed [POS_W-1:0]  y_pos_q;
	logic signed [VEL_W-1:0]  y_vel_q;
	logic [LVL_W-1:0]         a_lvl_q;
	logic signed [VEL_W-1:0]  a_vel_q;
	logic [GUARD_W-1:0]       guard_q;
	logic signed [RY_W-1:0]   last_y_q;
	logic signed [8:0]        last_a_q;
	logic signed [8:0]        last_m_q;
	logic signed [KD_W-1:0]   kd_q;
	logic signed [MUL_A_W-1:0] acc_q;
	logic [MASK_W-1:0]        mask_q;
	logic [M_TDATA_W-1:0]     out_q;
	logic                     out_vld_q;

	// datapath
	logic signed [EXT_W-1:0]   y_ext;
	logic signed [EXT_W-1:0]   a_ext;
	logic signed [EXT_W-1:0]   ty_ext;
	logic signed [EXT_W-1:0]   ta_ext;
	logic signed [EXT_W-1:0]   cur_pos;
	logic signed [EXT_W-1:0]   cur_tgt;
	logic signed [EXT_W-1:0]   diff;
	logic signed [VEL_W-1:0]   cur_vel;
	logic [9:0]                cur_k;
	logic [7:0]                cur_c;
	logic                      axis_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	prod_t                     p;
	prod_t                     acc_full;
	prod_t                     vsum;
	prod_t                     psum;
	logic signed [VEL_W-1:0]   vel_new;
	logic signed [POS_W-1:0]   ypos_new;
	logic [LVL_W-1:0]          lvl_new;
	logic [HGT_W-1:0]          hs;
	logic signed [EXT_W-1:0]   h_ext;
	logic signed [EXT_W-1:0]   hmy;
	logic                      y_ge_h;
	logic [24:0]               num25;
	logic                      mask_sat;
	logic                      mask_on;
	div_req_t                  div_req;
	logic                      div_done;
	logic [MASK_W-1:0]         div_quo;

	// result assembly
	logic [POS_W:0]            yb;
	logic signed [POS_W-FRAC_W:0] ry_full;
	logic signed [RY_W-1:0]    ry;
	logic [7:0]                ra;
	logic [MASK_W-1:0]         mask_val;
	logic                      yc;
	logic                      ac;
	logic                      mc;
	logic signed [EXT_W-1:0]   dy;
	logic signed [EXT_W-1:0]   da;
	logic                      y_ok;
	logic                      a_ok;
	logic                      idle_f;
	logic                      pulse;

	assign y_ext   = EXT_W'(y_pos_q);
	assign a_ext   = $signed({{(EXT_W-LVL_W){1'b0}}, a_lvl_q});
	assign ty_ext  = $signed({{(EXT_W-TY_W-FRAC_W){1'b0}}, ty_q, {FRAC_W{1'b0}}});
	assign ta_ext  = $signed({{(EXT_W-TA_W-FRAC_W){1'b0}}, ta_q, {FRAC_W{1'b0}}});
	assign cur_pos = axis_q ? a_ext : y_ext;
	assign cur_tgt = axis_q ? ta_ext : ty_ext;
	assign diff    = cur_pos - cur_tgt;
	assign cur_vel = axis_q ? a_vel_q : y_vel_q;
	assign cur_k   = axis_q ? a_tens_q : y_tens_q;
	assign cur_c   = axis_q ? a_fric_q : y_fric_q;
	assign axis_en = axis_q ? a_en_q : y_en_q;

	assign hs     = (scr_h_q == '0) ? HGT_W'(1) : scr_h_q;
	assign h_ext  = $signed({{(EXT_W-HGT_W-FRAC_W){1'b0}}, hs, {FRAC_W{1'b0}}});
	assign hmy    = h_ext - y_ext;
	assign y_ge_h = y_ext >= h_ext;
	assign mask_on = mask_max_q != '0;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_KD: begin
				mul_a = MUL_A_W'(diff);
				mul_b = MUL_B_W'(cur_k);
			end
			S_CV: begin
				mul_a = MUL_A_W'(cur_vel);
				mul_b = MUL_B_W'(cur_c);
			end
			S_ADT: begin
				mul_a = acc_q;
				mul_b = MUL_B_W'(dt_q);
			end
			S_VDT: begin
				mul_a = MUL_A_W'(cur_vel);
				mul_b = MUL_B_W'(dt_q);
			end
			S_MASK: begin
				mul_a = a_en_q ? MUL_A_W'(a_ext) : MUL_A_W'(hmy);
				mul_b = MUL_B_W'(mask_max_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dsda_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p)
	);

	// acceleration, velocity and position updates from the registered product
	assign acc_full = prod_t'(0) - prod_t'(kd_q) - p;
	assign vsum     = prod_t'(cur_vel) + trunc_step(p);
	assign psum     = prod_t'(cur_pos) + trunc_step(p);

	always_comb begin
		if (vsum > VEL_MAX) begin
			vel_new = VEL_MAX[VEL_W-1:0];
		end else if (vsum < VEL_MIN) begin
			vel_new = VEL_MIN[VEL_W-1:0];
		end else begin
			vel_new = vsum[VEL_W-1:0];
		end

		if (psum > POS_MAX) begin
			ypos_new = POS_MAX[POS_W-1:0];
		end else if (psum < POS_MIN) begin
			ypos_new = POS_MIN[POS_W-1:0];
		end else begin
			ypos_new = psum[POS_W-1:0];
		end

		if (psum < prod_t'(0)) begin
			lvl_new = '0;
		end else if (psum > LVL_MAX) begin
			lvl_new = LVL_RST;
		end else begin
			lvl_new = psum[LVL_W-1:0];
		end
	end

	// drawer mask: quotient saturates once it would reach 256
	assign num25    = p[FRAC_W+24:FRAC_W];
	assign mask_sat = num25 >= {4'b0000, hs, 8'h00};

	assign div_req.start = (state_q == S_MWAIT) && !a_en_q && !mask_sat;
	assign div_req.num   = num25[NUM_W-1:0];
	assign div_req.den   = hs;

	dsda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// render values, flags
	assign yb      = {y_pos_q[POS_W-1], y_pos_q} +
			{{(POS_W+1-FRAC_W){1'b0}}, {FRAC_W{y_pos_q[POS_W-1]}}};
	assign ry_full = yb[POS_W:FRAC_W];

	always_comb begin
		if (ry_full > (POS_W-FRAC_W+1)'(16383)) begin
			ry = 15'sd16383;
		end else if (ry_full < -(POS_W-FRAC_W+1)'(16384)) begin
			ry = -15'sd16384;
		end else begin
			ry = ry_full[RY_W-1:0];
		end
	end

	assign ra       = a_lvl_q[LVL_W-1:FRAC_W];
	assign mask_val = mask_on ? mask_q : '0;
	assign yc       = ry != last_y_q;
	assign ac       = $signed({1'b0, ra}) != last_a_q;
	assign mc       = mask_on && ($signed({1'b0, mask_q}) != last_m_q);

	assign dy     = ty_ext - y_ext;
	assign da     = ta_ext - a_ext;
	assign y_ok   = !y_en_q || ((dy < ONE_E) && (dy > -ONE_E) &&
			(y_vel_q < TWO_V) && (y_vel_q > -TWO_V));
	assign a_ok   = !a_en_q || ((da < ONE_E) && (da > -ONE_E) &&
			(a_vel_q < TWO_V) && (a_vel_q > -TWO_V));
	assign idle_f = y_ok && a_ok;
	assign pulse  = ({1'b0, guard_q} + 9'd1) > 9'(GUARD_LIMIT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_en_q     <= 1'b0;
			y_tens_q   <= '0;
			y_fric_q   <= '0;
			a_en_q     <= 1'b1;
			a_tens_q   <= 10'd170;
			a_fric_q   <= 8'd26;
			scr_h_q    <= 13'd1080;
			mask_max_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_Y_EN:     y_en_q     <= cfg_wdata[0];
				REG_Y_TENS:   y_tens_q   <= cfg_wdata[9:0];
				REG_Y_FRIC:   y_fric_q   <= cfg_wdata[7:0];
				REG_A_EN:     a_en_q     <= cfg_wdata[0];
				REG_A_TENS:   a_tens_q   <= cfg_wdata[9:0];
				REG_A_FRIC:   a_fric_q   <= cfg_wdata[7:0];
				REG_SCR_H:    scr_h_q    <= cfg_wdata[HGT_W-1:0];
				REG_MASK_MAX: mask_max_q <= cfg_wdata[MASK_W-1:0];
			endcase
		end
	end

	// sequencer, axis state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			axis_q    <= 1'b0;
			dt_q      <= '0;
			ty_q      <= '0;
			ta_q      <= '0;
			y_pos_q   <= '0;
			y_vel_q   <= '0;
			a_lvl_q   <= LVL_RST;
			a_vel_q   <= '0;
			guard_q   <= '0;
			last_y_q  <= LAST_Y_RST;
			last_a_q  <= '1;
			last_m_q  <= '1;
			kd_q      <= '0;
			acc_q     <= '0;
			mask_q    <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// the final state reloads the output register itself
			if (out_vld_q && m_tready && (state_q != S_FIN)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						dt_q    <= s_tuser ? slow_scale(s_tdata[DT_W-1:0]) : s_tdata[DT_W-1:0];
						ty_q    <= s_tdata[DT_W+TY_W-1:DT_W];
						ta_q    <= s_tdata[DT_W+TY_W+TA_W-1:DT_W+TY_W];
						axis_q  <= 1'b0;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					if (axis_en) begin
						state_q <= S_KD;
					end else if (axis_q) begin
						// disabled opacity axis sits fully opaque
						a_lvl_q <= LVL_RST;
						a_vel_q <= '0;
						state_q <= S_MASK;
					end else begin
						y_pos_q <= '0;
						y_vel_q <= '0;
						axis_q  <= 1'b1;
					end
				end
				S_KD: state_q <= S_CV;
				S_CV: begin
					kd_q    <= p[KD_W-1:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_full[MUL_A_W-1:0];
					state_q <= S_ADT;
				end
				S_ADT: state_q <= S_VEL;
				S_VEL: begin
					if (axis_q) begin
						a_vel_q <= vel_new;
					end else begin
						y_vel_q <= vel_new;
					end
					state_q <= S_VDT;
				end
				S_VDT: state_q <= S_POS;
				S_POS: begin
					if (axis_q) begin
						a_lvl_q <= lvl_new;
						state_q <= S_MASK;
					end else begin
						y_pos_q <= ypos_new;
						axis_q  <= 1'b1;
						state_q <= S_AXIS;
					end
				end
				S_MASK: begin
					if (!mask_on) begin
						state_q <= S_FIN;
					end else if (a_en_q) begin
						state_q <= S_MWAIT;
					end else if (y_ge_h) begin
						mask_q  <= '0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MWAIT;
					end
				end
				S_MWAIT: begin
					if (a_en_q) begin
						mask_q  <= div255(p[FRAC_W+15:FRAC_W]);
						state_q <= S_FIN;
					end else if (mask_sat) begin
						mask_q  <= '1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						mask_q  <= div_quo;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_vld_q || m_tready) begin
						out_q     <= {4'b0000, pulse, idle_f, mc, ac, yc, mask_val, ra, ry};
						out_vld_q <= 1'b1;
						last_y_q  <= ry;
						last_a_q  <= $signed({1'b0, ra});
						if (mask_on) begin
							last_m_q <= $signed({1'b0, mask_q});
						end
						guard_q   <= pulse ? '0 : guard_q + GUARD_W'(1);
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// self-checking testbench for the dual spring damper animator with its frame scoreboard

typedef struct {
	logic [11:0] step;
	logic [12:0] ty;
	logic [7:0]  ta;
	logic        slow;
} tick_t;

typedef struct {
	logic signed [14:0] ry;
	logic [7:0]         ra;
	logic [7:0]         mask;
	logic               yc;
	logic               ac;
	logic               mc;
	logic               idle;
	logic               pulse;
} frame_t;

class frame_scoreboard;
	localparam int FB = 16;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam longint A_FULL = 64'sd255 <<< FB;
	localparam int GUARD_MAX = 30;

	bit y_on, a_on;
	longint y_k, y_c, a_k, a_c, scr_h, mask_max;
	longint y_pos, y_vel, a_lvl, a_vel;
	int guard, last_y, last_a, last_m;
	frame_t frames[$];
	int errors, seen, idle_seen, pulses_seen, settings;

	function new();
		y_on = 0; y_k = 0; y_c = 0;
		a_on = 1; a_k = 170; a_c = 26;
		scr_h = 1080; mask_max = 0;
		y_pos = 0; y_vel = 0; a_lvl = A_FULL; a_vel = 0;
		guard = 0; last_y = -9999; last_a = -1; last_m = -1;
		errors = 0; seen = 0; idle_seen = 0; pulses_seen = 0; settings = 1;
	endfunction

	function void set_reg(dsda_pkg::cfg_reg_t r, int unsigned v);
		case (r)
			dsda_pkg::REG_Y_EN:     y_on = v[0];
			dsda_pkg::REG_Y_TENS:   y_k = v & 'h3FF;
			dsda_pkg::REG_Y_FRIC:   y_c = v & 'hFF;
			dsda_pkg::REG_A_EN:     a_on = v[0];
			dsda_pkg::REG_A_TENS:   a_k = v & 'h3FF;
			dsda_pkg::REG_A_FRIC:   a_c = v & 'hFF;
			dsda_pkg::REG_SCR_H:    scr_h = v & 'h1FFF;
			dsda_pkg::REG_MASK_MAX: mask_max = v & 'hFF;
			default: ;
		endcase
	endfunction

	// shift right with rounding toward zero
	function longint shr_tz(longint x, int s);
		if (x < 0)
			return -((-x) >>> s);
		return x >>> s;
	endfunction

	function longint clip(longint x, int bits);
		longint hi, lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function longint magn(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// semi-implicit euler: velocity first, then position with the new velocity
	function void spring(inout longint pos, inout longint vel, input longint tgt,
			input longint k, input longint c, input longint dt);
		longint acc;
		acc = -k * (pos - tgt) - c * vel;
		vel = clip(vel + shr_tz(acc * dt, 16), 40);
		pos = pos + shr_tz(vel * dt, 16);
	endfunction

	function void note_tick(tick_t t);
		longint dt, ty, ta, a, ry, ra, mask, h;
		frame_t f;
		bit y_ok, a_ok;
		dt = longint'(t.step);
		ty = longint'(t.ty) <<< FB;
		ta = longint'(t.ta) <<< FB;
		if (t.slow)
			dt = dt * 7 / 10;

		if (y_on) begin
			spring(y_pos, y_vel, ty, y_k, y_c, dt);
			y_pos = clip(y_pos, 32);
		end else begin
			y_pos = 0;
			y_vel = 0;
		end

		if (a_on) begin
			a = a_lvl;
			spring(a, a_vel, ta, a_k, a_c, dt);
			if (a < 0)
				a = 0;
			if (a > A_FULL)
				a = A_FULL;
			a_lvl = a;
		end else begin
			a_lvl = A_FULL;
			a_vel = 0;
		end

		ry = shr_tz(y_pos, FB);
		if (ry > 16383)
			ry = 16383;
		if (ry < -16384)
			ry = -16384;
		ra = a_lvl >>> FB;
		f.yc = (ry != last_y);
		last_y = int'(ry);
		f.ac = (ra != last_a);
		last_a = int'(ra);

		// mask off leaves the last mask value alone
		mask = 0;
		f.mc = 0;
		if (mask_max > 0) begin
			if (a_on) begin
				mask = mask_max * a_lvl / A_FULL;
			end else begin
				h = ((scr_h != 0) ? scr_h : 64'sd1) <<< FB;
				mask = (y_pos >= h) ? 64'sd0 : mask_max * (h - y_pos) / h;
			end
			if (mask > 255)
				mask = 255;
			f.mc = (mask != last_m);
			last_m = int'(mask);
		end

		y_ok = 1;
		a_ok = 1;
		if (y_on)
			y_ok = magn(ty - y_pos) < ONE && magn(y_vel) < 2 * ONE;
		if (a_on)
			a_ok = magn(ta - a_lvl) < ONE && magn(a_vel) < 2 * ONE;
		f.idle = y_ok && a_ok;

		f.pulse = 0;
		if (guard + 1 > GUARD_MAX) begin
			f.pulse = 1;
			guard = 0;
		end else begin
			guard++;
		end

		f.ry = ry[14:0];
		f.ra = ra[7:0];
		f.mask = mask[7:0];
		frames.push_back(f);
	endfunction

	function void compare_field(string name, logic signed [15:0] want, logic signed [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_frame(logic [39:0] d);
		frame_t got, want;
		got.ry = d[14:0];
		got.ra = d[22:15];
		got.mask = d[30:23];
		got.yc = d[31];
		got.ac = d[32];
		got.mc = d[33];
		got.idle = d[34];
		got.pulse = d[35];
		seen++;
		if (frames.size() == 0) begin
			errors++;
			$display("%0t: result with nothing expected, expected none actual %h", $time, d);
			return;
		end
		want = frames.pop_front();
		if (got.idle === 1'b1)
			idle_seen++;
		if (got.pulse === 1'b1)
			pulses_seen++;
		compare_field("render_y", want.ry, got.ry);
		compare_field("render_alpha", want.ra, got.ra);
		compare_field("mask_alpha", want.mask, got.mask);
		compare_field("y_changed", want.yc, got.yc);
		compare_field("alpha_changed", want.ac, got.ac);
		compare_field("mask_changed", want.mc, got.mc);
		compare_field("idle", want.idle, got.idle);
		compare_field("restack_pulse", want.pulse, got.pulse);
	endfunction
endclass

module tb_top;
	import dsda_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	cfg_reg_t              cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	frame_scoreboard sb;
	bit steady;
	int ticks_sent;

	dual_spring_damper_animator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver stalls at random unless in a steady stretch
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = steady || ($urandom_range(99) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_frame(m_tdata);
	end

	task automatic send_tick(input tick_t t);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 16) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'b0, t.ta, t.ty, t.step};
		s_tuser = t.slow;
		do @(posedge clk); while (!s_tready);
		sb.note_tick(t);
		ticks_sent++;
	endtask

	task automatic tick(input int step, input int ty, input int ta, input int slow);
		tick_t t;
		t.step = step[11:0];
		t.ty = ty[12:0];
		t.ta = ta[7:0];
		t.slow = slow[0];
		send_tick(t);
	endtask

	// stop sending and wait until every frame is back and the block is quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.frames.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input int unsigned v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = r;
		cfg_wdata = v[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_reg(r, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply(input int ye, input int yk, input int yc, input int ae,
			input int ak, input int ac, input int h, input int m);
		write_reg(REG_Y_EN, ye);
		write_reg(REG_Y_TENS, yk);
		write_reg(REG_Y_FRIC, yc);
		write_reg(REG_A_EN, ae);
		write_reg(REG_A_TENS, ak);
		write_reg(REG_A_FRIC, ac);
		write_reg(REG_SCR_H, h);
		write_reg(REG_MASK_MAX, m);
		sb.settings++;
	endtask

	// runs of ticks toward steady targets at a frame-like step, mixed with noise
	task automatic run_segments(input int n_items);
		int left, len, ty, ta, base, i;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(60, 150) : $urandom_range(4, 24);
			case ($urandom_range(3))
				0: ty = 0;
				1: ty = 8191;
				2: ty = $urandom_range(0, 200);
				default: ty = $urandom_range(0, 8191);
			endcase
			ta = ($urandom_range(1) == 0) ? 255 * $urandom_range(1) : $urandom_range(0, 255);
			case ($urandom_range(2))
				0: base = 546;
				1: base = 1092;
				default: base = 3277;
			endcase
			for (i = 0; i < len && left > 0; i++) begin
				if ($urandom_range(99) < 20)
					tick($urandom_range(0, 4095), $urandom_range(0, 8191),
						$urandom_range(0, 255), $urandom_range(1));
				else
					tick(base - $urandom_range(0, 20), ty, ta,
						int'((i < 3) && $urandom_range(1)));
				left--;
			end
			if ($urandom_range(19) == 0)
				settle();
		end
	endtask

	initial begin
		int p, ye, ae;
		sb = new();
		steady = 1'b0;
		ticks_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_Y_EN;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: offset axis off, mask off
		tick(0, 0, 0, 0);
		tick(4095, 8191, 255, 1);
		tick(4095, 0, 0, 0);
		tick(4095, 8191, 0, 1);
		tick(2048, 4096, 128, 0);
		settle();

		// stiffest springs; heavy offset damping over a long step runs away and saturates
		apply(1, 1023, 255, 1, 1023, 0, 8191, 255);
		for (p = 0; p < 8; p++)
			tick(4095, 8191, (p % 2) ? 255 : 0, 0);
		settle();

		// drawer mode with zero screen height, offset swings negative
		apply(1, 1023, 255, 0, 0, 255, 0, 200);
		for (p = 0; p < 6; p++)
			tick(4095, 0, 255, int'(p == 0));
		tick(0, 0, 255, 0);
		settle();

		for (p = 0; p < 8; p++) begin
			if (p == 0) begin
				apply(0, 0, 0, 1, 0, 0, 1, 1);
			end else if (p == 1) begin
				apply(1, 0, 0, 1, 170, 26, 8191, 0);
			end else if ($urandom_range(9) < 6) begin
				ye = int'($urandom_range(9) < 7);
				ae = int'($urandom_range(9) < 7);
				apply(ye, $urandom_range(20, 400), $urandom_range(5, 60), ae,
					$urandom_range(20, 400), $urandom_range(5, 60),
					($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8191),
					($urandom_range(3) == 0) ? 255 : $urandom_range(0, 255));
			end else begin
				apply($urandom_range(1), $urandom_range(0, 1023), $urandom_range(0, 255),
					$urandom_range(1), $urandom_range(0, 1023), $urandom_range(0, 255),
					$urandom_range(0, 8191), $urandom_range(0, 255));
			end
			steady = (p == 3);
			run_segments(90);
			steady = 1'b0;
			settle();
		end

		$display("%0d ticks under %0d register settings, %0d idle frames and %0d restack pulses",
			ticks_sent, sb.settings, sb.idle_seen, sb.pulses_seen);
		if (sb.errors == 0 && sb.frames.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
